### src/yuv422_to_rgb_bright_spot_locator_defines.svh
// Assertion macros shared by the bright spot locator RTL.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef YUV422_TO_RGB_BRIGHT_SPOT_LOCATOR_DEFINES_SVH
`define YUV422_TO_RGB_BRIGHT_SPOT_LOCATOR_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define YBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define YBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ybs_pkg.sv
// Shared types and constants of the YUV 4:2:2 to RGB bright spot locator.
// No dependencies; used by every module of the block.
package ybs_pkg;

    // Configuration port.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET      = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET     = 13'd360;
    localparam logic [7:0]       BRIGHT_THRESHOLD_RESET = 8'd250;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [7:0]       bright_threshold;
    } t_cfg;

    // Defaults of the top level parameters.
    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Fixed widths of the stream payloads.
    localparam int PIX_W      = 8;
    localparam int OUT_COORD_W = 12;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 80;

    // BT.601 integer conversion constants.
    localparam int COEF_Y    = 298;
    localparam int COEF_RV   = 409;
    localparam int COEF_GU   = 100;
    localparam int COEF_GV   = 208;
    localparam int COEF_BU   = 516;
    localparam int ROUND_ADD = 128;
    localparam int Y_OFFSET  = 16;
    localparam int C_OFFSET  = 128;
    localparam int CH_MAX    = 255;

    // Direction codes of a report.
    localparam logic [1:0] DIR_BACK    = 2'd0;
    localparam logic [1:0] DIR_LEFT    = 2'd1;
    localparam logic [1:0] DIR_RIGHT   = 2'd2;
    localparam logic [1:0] DIR_FORWARD = 2'd3;

endpackage

### src/ybs_front.sv
// Front end of the locator: accepts pixel pairs and stamps each with its raster position.
// Depends on ybs_pkg; feeds ybs_queue.
module ybs_front #(
    parameter int COORD_BITS = ybs_pkg::COORD_BITS_DEFAULT,
    parameter int ENTRY_W    = 2 * COORD_BITS + 1 + ybs_pkg::S_DATA_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ybs_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ybs_pkg::S_DATA_W-1:0] i_data,
    input  logic                         i_frame_start,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [ENTRY_W-1:0]           o_entry
);

    localparam int HC_W  = COORD_BITS + 1;
    localparam int CMP_W = (HC_W > ybs_pkg::CFG_W) ? HC_W : ybs_pkg::CFG_W;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] w_col, w_row;
    logic [HC_W-1:0]       w_col_next, w_row_next;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // A frame start pair sits at the origin whatever the counters hold.
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;

    assign w_col_next = HC_W'(w_col) + HC_W'(2);
    assign w_row_next = HC_W'(w_row) + HC_W'(1);

    always_comb begin
        n_col = w_col_next[COORD_BITS-1:0];
        n_row = w_row;
        if (CMP_W'(w_col_next) >= CMP_W'(i_cfg.frame_width) || w_col_next[COORD_BITS]) begin
            n_col = '0;
            n_row = w_row_next[COORD_BITS-1:0];
            if (CMP_W'(w_row_next) >= CMP_W'(i_cfg.frame_height) || w_row_next[COORD_BITS]) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_entry = {w_row, w_col, i_frame_start, i_data};

endmodule

### src/ybs_queue.sv
// Short FIFO between the front end and the conversion pipeline.
// Depends on ybs_pkg and the assertion macro header; DEPTH must be a power of two, two or more.
`include "yuv422_to_rgb_bright_spot_locator_defines.svh"

module ybs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ybs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `YBS_ASSERT(q_count_range, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `YBS_ASSERT_NEXT(q_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue lost a push")

endmodule

### src/ybs_back.sv
// Back end of the locator: BT.601 conversion pipeline, bright spot search and output register.
// Depends on ybs_pkg and the assertion macro header; drains ybs_queue.
`include "yuv422_to_rgb_bright_spot_locator_defines.svh"

module ybs_back #(
    parameter int COORD_BITS = ybs_pkg::COORD_BITS_DEFAULT,
    parameter int ENTRY_W    = 2 * COORD_BITS + 1 + ybs_pkg::S_DATA_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ybs_pkg::t_cfg                i_cfg,
    input  logic [ENTRY_W-1:0]           i_entry,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ybs_pkg::M_DATA_W-1:0] o_data,
    output logic                         o_hit
);

    localparam int PW    = ybs_pkg::PIX_W;
    localparam int OCW   = ybs_pkg::OUT_COORD_W;
    localparam int AW    = 20;
    localparam int HC_W  = COORD_BITS + 1;
    localparam int CMP_W = (HC_W > ybs_pkg::CFG_W) ? HC_W : ybs_pkg::CFG_W;
    localparam int EXT_W = (HC_W > OCW) ? HC_W : OCW;
    localparam int DIR_LO = 6 * PW;
    localparam int ROW_HI = DIR_LO + 2 + 2 * OCW - 1;

    function automatic logic [PW-1:0] clamp8(input logic signed [AW-1:0] t);
        logic [AW-9:0] q;
        q = t[AW-1:8];
        if (t < 0) begin
            return '0;
        end else if (q > (AW-8)'(ybs_pkg::CH_MAX)) begin
            return PW'(ybs_pkg::CH_MAX);
        end else begin
            return q[PW-1:0];
        end
    endfunction

    // Stage 0: unpack the queue head.
    logic [PW-1:0]         w_y0, w_y1, w_u, w_v;
    logic                  w_fs;
    logic [COORD_BITS-1:0] w_col, w_row;
    logic signed [AW-1:0]  w_c0, w_c1, w_d, w_e;

    assign {w_row, w_col, w_fs, w_v, w_u, w_y1, w_y0} = i_entry;

    assign w_c0 = signed'(AW'(w_y0)) - signed'(AW'(ybs_pkg::Y_OFFSET));
    assign w_c1 = signed'(AW'(w_y1)) - signed'(AW'(ybs_pkg::Y_OFFSET));
    assign w_d  = signed'(AW'(w_u)) - signed'(AW'(ybs_pkg::C_OFFSET));
    assign w_e  = signed'(AW'(w_v)) - signed'(AW'(ybs_pkg::C_OFFSET));

    logic w_adv;
    assign w_adv = !o_valid || i_ready;
    assign o_pop = w_adv && !i_empty;

    // Stage 1: products.
    logic                  r1_valid, r1_fs;
    logic [COORD_BITS-1:0] r1_col, r1_row;
    logic signed [AW-1:0]  r1_py0, r1_py1, r1_rv, r1_gu, r1_gv, r1_bu;

    // Stage 2: clamped channels.
    logic                  r2_valid, r2_fs;
    logic [COORD_BITS-1:0] r2_col, r2_row;
    logic [PW-1:0]         r2_rgb [6];

    // Stage 3: output register and search state.
    logic                  r_out_valid, r_out_hit;
    logic [ybs_pkg::M_DATA_W-1:0] r_out_data;
    logic                  r_hit_seen;

    logic signed [AW-1:0]  w_rnd;
    assign w_rnd = signed'(AW'(ybs_pkg::ROUND_ADD));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_fs  <= w_fs;
            r1_col <= w_col;
            r1_row <= w_row;
            r1_py0 <= w_c0 * signed'(AW'(ybs_pkg::COEF_Y));
            r1_py1 <= w_c1 * signed'(AW'(ybs_pkg::COEF_Y));
            r1_rv  <= w_e * signed'(AW'(ybs_pkg::COEF_RV));
            r1_gu  <= w_d * signed'(AW'(ybs_pkg::COEF_GU));
            r1_gv  <= w_e * signed'(AW'(ybs_pkg::COEF_GV));
            r1_bu  <= w_d * signed'(AW'(ybs_pkg::COEF_BU));

            r2_fs     <= r1_fs;
            r2_col    <= r1_col;
            r2_row    <= r1_row;
            r2_rgb[0] <= clamp8(r1_py0 + r1_rv + w_rnd);
            r2_rgb[1] <= clamp8(r1_py0 - r1_gu - r1_gv + w_rnd);
            r2_rgb[2] <= clamp8(r1_py0 + r1_bu + w_rnd);
            r2_rgb[3] <= clamp8(r1_py1 + r1_rv + w_rnd);
            r2_rgb[4] <= clamp8(r1_py1 - r1_gu - r1_gv + w_rnd);
            r2_rgb[5] <= clamp8(r1_py1 + r1_bu + w_rnd);
        end
    end

    // Search: the left pixel wins when both pixels are bright.
    logic                  w_bright_l, w_bright_r, w_seen, w_hit;
    logic [HC_W-1:0]       w_hcol;
    logic [COORD_BITS-1:0] w_hrow;
    logic [1:0]            w_dir;
    logic [CMP_W-1:0]      w_col_ext, w_fw, w_fw_q, w_fh_q, w_row_ext;
    logic [EXT_W-1:0]      w_hcol_out, w_hrow_out;
    logic [ybs_pkg::M_DATA_W-1:0] n_out_data;

    assign w_bright_l = r2_rgb[0] >= i_cfg.bright_threshold
                     && r2_rgb[1] >= i_cfg.bright_threshold
                     && r2_rgb[2] >= i_cfg.bright_threshold;
    assign w_bright_r = r2_rgb[3] >= i_cfg.bright_threshold
                     && r2_rgb[4] >= i_cfg.bright_threshold
                     && r2_rgb[5] >= i_cfg.bright_threshold;
    assign w_seen = r_hit_seen && !r2_fs;
    assign w_hit  = !w_seen && (w_bright_l || w_bright_r);

    assign w_fw      = CMP_W'(i_cfg.frame_width);
    assign w_fw_q    = CMP_W'(i_cfg.frame_width >> 2);
    assign w_fh_q    = CMP_W'(i_cfg.frame_height >> 2);
    assign w_col_ext = CMP_W'(w_hcol);
    assign w_row_ext = CMP_W'(r2_row);

    always_comb begin
        w_hcol = '0;
        w_hrow = '0;
        w_dir  = ybs_pkg::DIR_BACK;
        if (w_hit) begin
            w_hcol = w_bright_l ? HC_W'(r2_col) : HC_W'(r2_col) + HC_W'(1);
            w_hrow = r2_row;
            if (w_row_ext < w_fh_q) begin
                w_dir = ybs_pkg::DIR_BACK;
            end else if (w_col_ext < w_fw_q) begin
                w_dir = ybs_pkg::DIR_LEFT;
            end else if (w_col_ext > w_fw - w_fw_q) begin
                w_dir = ybs_pkg::DIR_RIGHT;
            end else begin
                w_dir = ybs_pkg::DIR_FORWARD;
            end
        end
    end

    assign w_hcol_out = EXT_W'(w_hcol);
    assign w_hrow_out = EXT_W'(w_hrow);
    assign n_out_data = {{(ybs_pkg::M_DATA_W - ROW_HI - 1){1'b0}},
                         w_hrow_out[OCW-1:0], w_hcol_out[OCW-1:0], w_dir,
                         r2_rgb[5], r2_rgb[4], r2_rgb[3],
                         r2_rgb[2], r2_rgb[1], r2_rgb[0]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
            r_out_hit  <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit_seen  <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= !i_empty;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
            if (r2_valid) begin
                r_hit_seen <= w_seen || w_hit;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_hit   = r_out_hit;

    `YBS_ASSERT(b_quiet_fields, r_out_valid && !r_out_hit |-> r_out_data[ROW_HI:DIR_LO] == '0, "report fields set without a hit")
    `YBS_ASSERT_NEXT(b_seen_after_hit, w_adv && r2_valid && w_hit, r_hit_seen, "hit not recorded")
    `YBS_ASSERT(b_single_hit, w_adv && r2_valid && r_hit_seen && !r2_fs |-> !w_hit, "second hit in one frame")

endmodule

### src/yuv422_to_rgb_bright_spot_locator.sv
// Top level of the YUV 4:2:2 to RGB888 converter with bright spot locator.
// Depends on ybs_pkg, ybs_front, ybs_queue and ybs_back.
//
// The block takes one 4:2:2 pixel pair per request on the slave stream and returns, for every
// pair, one request on the master stream with both pixels converted to 8-bit RGB using the
// BT.601 integer formula, clamped to 0..255. It keeps the raster position of each pair from
// frame_width and frame_height, and marks the first pixel of each frame whose red, green and
// blue all reach bright_threshold: hit_report goes high on that pair's result, with the pixel's
// column and row and a coarse direction (back for the top quarter of rows, else left, right or
// forward by column quarter). Without a hit those three fields are zero. When both pixels of a
// pair are bright the left one is reported. A pair flagged as frame start sits at column zero,
// row zero, and opens a new search. The sustained rate is one pair per clock while the master
// side takes results; an accepted pair passes through the queue, two entries deep by default,
// and then the three registers of the conversion pipeline (products, clamped sums, search and
// output register). The pipeline stalls as a whole when its output register is held, and the
// queue keeps the slave side open meanwhile until it fills. Configuration is written through
// the plain write port, by the user only while the block is idle (the block does not enforce it).
module yuv422_to_rgb_bright_spot_locator #(
    parameter int COORD_BITS  = ybs_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = ybs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Configuration write port.
    input  logic                          i_cfg_wr_en,
    input  logic [ybs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ybs_pkg::CFG_W-1:0]     i_cfg_data,

    // Pixel pair stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // luma_first[7:0], luma_second[15:8], chroma_blue[23:16], chroma_red[31:24]
    input  logic [ybs_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // frame_start[0]
    input  logic [0:0]                    s_axis_tuser,

    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // red_first[7:0], green_first[15:8], blue_first[23:16], red_second[31:24],
    // green_second[39:32], blue_second[47:40], direction[49:48], hit_column[61:50],
    // hit_row[73:62], zeros above
    output logic [ybs_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // hit_report[0]
    output logic [0:0]                    m_axis_tuser
);

    localparam int ENTRY_W = 2 * COORD_BITS + 1 + ybs_pkg::S_DATA_W;

    // Configuration registers; the user must write them only while no pair is in flight, unenforced here.
    ybs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width      <= ybs_pkg::FRAME_WIDTH_RESET;
            r_cfg.frame_height     <= ybs_pkg::FRAME_HEIGHT_RESET;
            r_cfg.bright_threshold <= ybs_pkg::BRIGHT_THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ybs_pkg::REG_FRAME_WIDTH:      r_cfg.frame_width      <= i_cfg_data;
                ybs_pkg::REG_FRAME_HEIGHT:     r_cfg.frame_height     <= i_cfg_data;
                ybs_pkg::REG_BRIGHT_THRESHOLD: r_cfg.bright_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    logic               w_push, w_pop, w_full, w_empty;
    logic [ENTRY_W-1:0] w_wr_entry, w_rd_entry;

    // The front end stamps each accepted pair with its column and row.
    ybs_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_frame_start (s_axis_tuser[0]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_wr_entry)
    );

    // The queue lets the front end keep accepting while the result side is held.
    ybs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_wr_entry),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_entry),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    // The back end converts, searches and holds the result for the master side.
    ybs_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_entry (w_rd_entry),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_hit   (m_axis_tuser[0])
    );

endmodule

### bench/yuv422_to_rgb_bright_spot_locator_test.sv
// Self-checking bench for the YUV 4:2:2 to RGB bright spot locator: directed table, then random.
// Depends on ybs_pkg and the top level yuv422_to_rgb_bright_spot_locator; nothing else.
// Every accepted pair goes through a local BT.601 and raster-search predictor, field by field.
module yuv422_to_rgb_bright_spot_locator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_PAUSE   = 8;
    localparam int END_PAUSE     = 20;
    localparam int NUM_DIRECTED  = 19;
    localparam int NUM_PHASES    = 26;
    localparam int LONG_ROW_RUN  = 220;
    localparam int COORD_MAX     = 4095;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_start;
    } t_pixel_pair;

    typedef struct packed {
        logic [7:0]  red_first;
        logic [7:0]  green_first;
        logic [7:0]  blue_first;
        logic [7:0]  red_second;
        logic [7:0]  green_second;
        logic [7:0]  blue_second;
        logic        hit_report;
        logic [1:0]  direction;
        logic [11:0] hit_column;
        logic [11:0] hit_row;
    } t_rgb_result;

    // One line of the directed table. When typed is set, want is the result read straight off the
    // formula; otherwise the predictor decides.
    typedef struct packed {
        t_pixel_pair pair;
        logic        typed;
        t_rgb_result want;
    } t_directed_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [ybs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ybs_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ybs_pkg::S_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]                    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ybs_pkg::M_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]                    m_axis_tuser;

    yuv422_to_rgb_bright_spot_locator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the raster search state.
    int unsigned cfg_width     = 32'(ybs_pkg::FRAME_WIDTH_RESET);
    int unsigned cfg_height    = 32'(ybs_pkg::FRAME_HEIGHT_RESET);
    int unsigned cfg_threshold = 32'(ybs_pkg::BRIGHT_THRESHOLD_RESET);
    int unsigned scan_column   = 0;
    int unsigned scan_row      = 0;
    bit          spot_found    = 1'b0;

    t_rgb_result   predicted_pairs[$];
    t_directed_row directed_table [NUM_DIRECTED];

    int  error_count  = 0;
    int  result_index = 0;
    int  cycle_count  = 0;
    bit  sink_steady  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor shift by 8 and saturate to one byte; negative sums go to zero.
    function automatic logic [7:0] clamp_channel(int t);
        if (t < 0) return 8'd0;
        t = t >>> 8;
        if (t > ybs_pkg::CH_MAX) return 8'd255;
        return t[7:0];
    endfunction

    task automatic convert_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v,
                                 output logic [7:0] r, output logic [7:0] g,
                                 output logic [7:0] b);
        int c, d, e;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        r = clamp_channel(298 * c + 409 * e + 128);
        g = clamp_channel(298 * c - 100 * d - 208 * e + 128);
        b = clamp_channel(298 * c + 516 * d + 128);
    endtask

    // Top quarter of the rows is "back"; below that the column picks left, right or forward.
    function automatic logic [1:0] spot_direction(int unsigned col, int unsigned row);
        if (row < cfg_height / 4) return ybs_pkg::DIR_BACK;
        if (col < cfg_width / 4) return ybs_pkg::DIR_LEFT;
        if (col > cfg_width - cfg_width / 4) return ybs_pkg::DIR_RIGHT;
        return ybs_pkg::DIR_FORWARD;
    endfunction

    task automatic convert_and_locate(input t_pixel_pair p, output t_rgb_result res);
        logic [7:0]  r0, g0, b0, r1, g1, b1;
        int unsigned col, row, nxt, spot_col;
        bit          bright0, bright1, hit;
        res = '0;
        if (p.frame_start) begin
            scan_column = 0;
            scan_row    = 0;
            spot_found  = 1'b0;
        end
        col = scan_column;
        row = scan_row;
        convert_pixel(p.luma_first, p.chroma_blue, p.chroma_red, r0, g0, b0);
        convert_pixel(p.luma_second, p.chroma_blue, p.chroma_red, r1, g1, b1);
        res.red_first    = r0;
        res.green_first  = g0;
        res.blue_first   = b0;
        res.red_second   = r1;
        res.green_second = g1;
        res.blue_second  = b1;

        bright0  = (r0 >= cfg_threshold) && (g0 >= cfg_threshold) && (b0 >= cfg_threshold);
        bright1  = (r1 >= cfg_threshold) && (g1 >= cfg_threshold) && (b1 >= cfg_threshold);
        hit      = 1'b0;
        spot_col = 0;
        if (!spot_found) begin
            // The left pixel wins when both are bright.
            if (bright0) begin
                hit      = 1'b1;
                spot_col = col;
            end else if (bright1) begin
                hit      = 1'b1;
                spot_col = col + 1;
            end
            if (hit) begin
                spot_found     = 1'b1;
                res.hit_report = 1'b1;
                res.hit_column = spot_col[11:0];
                res.hit_row    = row[11:0];
                res.direction  = spot_direction(spot_col, row);
            end
        end

        // Raster advance; an odd or zero width still wraps, and so does the coordinate range.
        nxt = col + 2;
        if (nxt >= cfg_width || nxt > COORD_MAX) begin
            nxt = 0;
            row = row + 1;
            if (row >= cfg_height || row > COORD_MAX) row = 0;
        end
        scan_column = nxt;
        scan_row    = row;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      result_index, name, got, want));
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_rgb_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red_first    = m_axis_tdata[7:0];
            got.green_first  = m_axis_tdata[15:8];
            got.blue_first   = m_axis_tdata[23:16];
            got.red_second   = m_axis_tdata[31:24];
            got.green_second = m_axis_tdata[39:32];
            got.blue_second  = m_axis_tdata[47:40];
            got.direction    = m_axis_tdata[49:48];
            got.hit_column   = m_axis_tdata[61:50];
            got.hit_row      = m_axis_tdata[73:62];
            got.hit_report   = m_axis_tuser[0];
            if (predicted_pairs.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no pair pending",
                                          result_index));
            end else begin
                want = predicted_pairs.pop_front();
                check_field("red_first", 32'(got.red_first), 32'(want.red_first));
                check_field("green_first", 32'(got.green_first), 32'(want.green_first));
                check_field("blue_first", 32'(got.blue_first), 32'(want.blue_first));
                check_field("red_second", 32'(got.red_second), 32'(want.red_second));
                check_field("green_second", 32'(got.green_second), 32'(want.green_second));
                check_field("blue_second", 32'(got.blue_second), 32'(want.blue_second));
                check_field("hit_report", 32'(got.hit_report), 32'(want.hit_report));
                check_field("direction", 32'(got.direction), 32'(want.direction));
                check_field("hit_column", 32'(got.hit_column), 32'(want.hit_column));
                check_field("hit_row", 32'(got.hit_row), 32'(want.hit_row));
            end
            result_index++;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: alternating ready and stall stretches, most stalls short and a
    // few long. A steady phase keeps ready high throughout.
    // ------------------------------------------------------------------
    initial begin : sink_ready_gen
        int hold;
        bit level;
        hold  = 0;
        level = 1'b1;
        forever begin
            @(posedge i_clk);
            if (sink_steady) begin
                level = 1'b1;
                hold  = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                level = ~level;
                if (level) hold = $urandom_range(1, 24);
                else if ($urandom_range(0, 99) < 85) hold = $urandom_range(0, 2);
                else hold = $urandom_range(8, 40);
            end
            m_axis_tready <= level;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pixel_pair px(logic [7:0] y0, logic [7:0] y1, logic [7:0] u,
                                       logic [7:0] v, logic fs);
        t_pixel_pair p;
        p.luma_first  = y0;
        p.luma_second = y1;
        p.chroma_blue = u;
        p.chroma_red  = v;
        p.frame_start = fs;
        return p;
    endfunction

    // Expected result where each pixel is a neutral gray, so R, G and B are equal.
    function automatic t_rgb_result gray_result(logic [7:0] left, logic [7:0] right, logic hit,
                                                logic [1:0] dir, logic [11:0] col,
                                                logic [11:0] row);
        t_rgb_result r;
        r.red_first    = left;
        r.green_first  = left;
        r.blue_first   = left;
        r.red_second   = right;
        r.green_second = right;
        r.blue_second  = right;
        r.hit_report   = hit;
        r.direction    = dir;
        r.hit_column   = col;
        r.hit_row      = row;
        return r;
    endfunction

    // Idle cycles after a request: mostly none, sometimes a few, rarely a long pause.
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random pair. Frame start lands on the real frame boundary most of the time, with a little
    // noise elsewhere; some pairs are forced near white so the search finds spots anywhere.
    function automatic t_pixel_pair random_pair(bit force_start, bit noise_starts);
        t_pixel_pair p;
        int          mode;
        p.luma_first  = 8'($urandom_range(0, 255));
        p.luma_second = 8'($urandom_range(0, 255));
        p.chroma_blue = 8'($urandom_range(0, 255));
        p.chroma_red  = 8'($urandom_range(0, 255));
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
            if ($urandom_range(0, 2) != 0) p.luma_first = 8'($urandom_range(225, 255));
            if ($urandom_range(0, 2) != 0) p.luma_second = 8'($urandom_range(225, 255));
            p.chroma_blue = 8'($urandom_range(118, 138));
            p.chroma_red  = 8'($urandom_range(118, 138));
        end else if (mode < 22) begin
            p.luma_first  = 8'($urandom_range(0, 40));
            p.luma_second = 8'($urandom_range(0, 40));
        end
        p.frame_start = force_start ||
                        (scan_column == 0 && scan_row == 0 && $urandom_range(0, 9) != 0) ||
                        (noise_starts && $urandom_range(0, 49) == 0);
        return p;
    endfunction

    // Present one pair, hold it until accepted, then predict its result. Must be called in the
    // time step of a rising edge; valid stays high into the next call when there is no gap.
    task automatic send_pair(input t_pixel_pair p, input bit typed, input t_rgb_result want,
                             input int gap);
        t_rgb_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.chroma_red, p.chroma_blue, p.luma_second, p.luma_first};
        s_axis_tuser  <= p.frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        convert_and_locate(p, predicted);
        predicted_pairs.push_back(typed ? want : predicted);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for every pending result, then a few more cycles so the pipeline is empty.
    task automatic wait_drained();
        while (predicted_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; the enable drops once at the end.
    task automatic apply_settings(input int unsigned width, input int unsigned height,
                                  input int unsigned thr);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ybs_pkg::REG_FRAME_WIDTH;
        i_cfg_data  <= width[ybs_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_width = width & 32'h1FFF;
        i_cfg_index <= ybs_pkg::REG_FRAME_HEIGHT;
        i_cfg_data  <= height[ybs_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_height = height & 32'h1FFF;
        i_cfg_index <= ybs_pkg::REG_BRIGHT_THRESHOLD;
        i_cfg_data  <= ybs_pkg::CFG_W'(thr & 32'hFF);
        @(posedge i_clk);
        cfg_threshold = thr & 32'hFF;
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int          phase, n_items, k, width, height, thr, r;
        bit          src_steady, noise_starts, long_run;
        t_rgb_result no_check;

        no_check = '0;

        // Directed table, run with the reset settings (640 x 360, threshold 250). The typed rows
        // are full black or full white pixels, whose results are plain saturation.
        directed_table = '{
            // White pair opening a frame: left pixel is the spot, top rows read back.
            '{px(8'd255, 8'd255, 8'd128, 8'd128, 1'b1), 1'b1,
              gray_result(8'd255, 8'd255, 1'b1, ybs_pkg::DIR_BACK, 12'd0, 12'd0)},
            // Black pair, spot already found: all zero, no report.
            '{px(8'd0, 8'd0, 8'd128, 8'd128, 1'b0), 1'b1,
              gray_result(8'd0, 8'd0, 1'b0, ybs_pkg::DIR_BACK, 12'd0, 12'd0)},
            '{px(8'd255, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, no_check},
            '{px(8'd0, 8'd255, 8'd255, 8'd255, 1'b0), 1'b0, no_check},
            '{px(8'd255, 8'd255, 8'd255, 8'd255, 1'b0), 1'b0, no_check},
            '{px(8'd255, 8'd255, 8'd0, 8'd255, 1'b0), 1'b0, no_check},
            '{px(8'd255, 8'd255, 8'd255, 8'd0, 1'b0), 1'b0, no_check},
            '{px(8'd16, 8'd235, 8'd128, 8'd128, 1'b0), 1'b0, no_check},
            // Only the right pixel is bright: it is reported at column 1.
            '{px(8'd0, 8'd255, 8'd128, 8'd128, 1'b1), 1'b1,
              gray_result(8'd0, 8'd255, 1'b1, ybs_pkg::DIR_BACK, 12'd1, 12'd0)},
            // Second bright pair in the same frame: no further report.
            '{px(8'd255, 8'd255, 8'd128, 8'd128, 1'b0), 1'b1,
              gray_result(8'd255, 8'd255, 1'b0, ybs_pkg::DIR_BACK, 12'd0, 12'd0)},
            '{px(8'd128, 8'd128, 8'd128, 8'd128, 1'b1), 1'b0, no_check},
            '{px(8'd235, 8'd240, 8'd128, 8'd128, 1'b0), 1'b0, no_check},
            '{px(8'd81, 8'd145, 8'd90, 8'd240, 1'b1), 1'b0, no_check},
            '{px(8'd41, 8'd210, 8'd240, 8'd110, 1'b0), 1'b0, no_check},
            '{px(8'd170, 8'd106, 8'd166, 8'd16, 1'b0), 1'b0, no_check},
            '{px(8'd1, 8'd254, 8'd1, 8'd254, 1'b0), 1'b0, no_check},
            '{px(8'd254, 8'd1, 8'd254, 8'd1, 1'b0), 1'b0, no_check},
            '{px(8'd0, 8'd0, 8'd0, 8'd0, 1'b1), 1'b0, no_check},
            '{px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1), 1'b0, no_check}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++)
            send_pair(directed_table[k].pair, directed_table[k].typed, directed_table[k].want,
                      pick_gap(1'b0));
        s_axis_tvalid <= 1'b0;

        // Random phases, each with its own geometry and threshold. The first few pin the
        // extremes: minimum frame, maximum frame, a long run without noise starts that wraps
        // rows and whole frames of a small picture, zero width, zero height with an odd width,
        // and the reset values again.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            noise_starts = 1'b1;
            long_run     = 1'b0;
            n_items      = $urandom_range(40, 100);
            case (phase)
                0: begin width = 2;    height = 1;    thr = 0;   n_items = 40; end
                1: begin width = 4096; height = 4096; thr = 255; n_items = 60; end
                2: begin
                    width    = 200;
                    height   = 2;
                    thr      = $urandom_range(240, 255);
                    n_items  = LONG_ROW_RUN;
                    long_run = 1'b1;
                end
                3: begin width = 0;    height = 5;    thr = $urandom_range(0, 255); end
                4: begin width = 7;    height = 0;    thr = $urandom_range(200, 255); end
                5: begin width = 640;  height = 360;  thr = 250; end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 45) width = 2 * $urandom_range(1, 12);
                    else if (r < 65) width = 2 * $urandom_range(1, 11) + 1;
                    else if (r < 85) width = $urandom_range(2, 300);
                    else width = $urandom_range(2, 4096);
                    r = $urandom_range(0, 99);
                    if (r < 70) height = $urandom_range(1, 12);
                    else if (r < 90) height = $urandom_range(1, 64);
                    else height = $urandom_range(1, 4096);
                    r = $urandom_range(0, 99);
                    if (r < 20) thr = 0;
                    else if (r < 35) thr = 255;
                    else if (r < 75) thr = $urandom_range(220, 255);
                    else thr = $urandom_range(0, 255);
                end
            endcase
            if (long_run) noise_starts = 1'b0;
            apply_settings(width, height, thr);

            // Some phases run without any idling on one or both sides.
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            for (k = 0; k < n_items; k++)
                send_pair(random_pair(k == 0, noise_starts), 1'b0, no_check,
                          pick_gap(src_steady));
            s_axis_tvalid <= 1'b0;
            sink_steady = 1'b0;
        end

        while (predicted_pairs.size() != 0) @(posedge i_clk);
        repeat (END_PAUSE) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/ybs_pkg.sv
src/ybs_front.sv
src/ybs_queue.sv
src/ybs_back.sv
src/yuv422_to_rgb_bright_spot_locator.sv
bench/yuv422_to_rgb_bright_spot_locator_test.sv
